[rtl/wscfm_pkg.sv]
// Shared types and constants for the WebSocket client frame masker.
// Used by the front, queue, back and top-level modules; depends on nothing.
package wscfm_pkg;

  // Item mode codes
  localparam logic ModeStart   = 1'b0;
  localparam logic ModePayload = 1'b1;

  // Header constants
  localparam logic [7:0]  HdrFinText   = 8'h81;
  localparam logic [7:0]  HdrMaskBit   = 8'h80;
  localparam logic [62:0] LenDirectMax = 63'd125;
  localparam logic [62:0] Len16Max     = 63'h0000_0000_0000_ffff;
  localparam logic [6:0]  LenCode16    = 7'd126;
  localparam logic [6:0]  LenCode64    = 7'd127;

  // Header byte counts: 0x81, length code, extended length, mask key
  localparam int unsigned MaskBytes   = 4;
  localparam int unsigned HdrMaxBytes = 2 + 8 + MaskBytes;
  localparam int unsigned HdrIdxW     = $clog2(HdrMaxBytes);

  typedef enum logic [1:0] {
    LenDirect = 2'd0,
    Len16     = 2'd1,
    Len64     = 2'd2
  } len_kind_e;

  typedef struct packed {
    logic        mode;
    logic [62:0] payload_length;
    logic [31:0] mask_key;
    logic [7:0]  payload_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_last;
  } out_item_t;

  // Work request passed from front to back
  typedef struct packed {
    logic        is_hdr;    // header request, else one masked byte
    len_kind_e   kind;      // length encoding of a header
    logic        len_zero;  // header closes the frame by itself
    logic [62:0] len;
    logic [31:0] key;
    logic [7:0]  data;      // masked payload byte
    logic        last;      // final payload byte of the frame
  } job_t;

endpackage

[rtl/wscfm_front.sv]
// Front end: accepts items, tracks the open frame and requests all but stray payload.
// Depends on wscfm_pkg.
module wscfm_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  wscfm_pkg::in_item_t  in_item_i,
  output logic                 push_valid_o,
  input  logic                 push_ready_i,
  output wscfm_pkg::job_t      push_job_o
);
  import wscfm_pkg::*;

  logic [31:0] key_q, key_d;
  logic [62:0] rem_q, rem_d;
  logic [1:0]  pos_q, pos_d;
  logic        open_q, open_d;
  logic        accept;
  logic        last_byte;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;
  assign last_byte  = (rem_q == 63'd1);

  // Classify the item and build the request
  always_comb begin
    push_job_o          = '0;
    push_job_o.len      = in_item_i.payload_length;
    push_job_o.key      = in_item_i.mask_key;
    push_job_o.len_zero = (in_item_i.payload_length == '0);
    if (in_item_i.payload_length <= LenDirectMax) begin
      push_job_o.kind = LenDirect;
    end else if (in_item_i.payload_length <= Len16Max) begin
      push_job_o.kind = Len16;
    end else begin
      push_job_o.kind = Len64;
    end
    push_job_o.data = in_item_i.payload_byte ^ key_q[8*pos_q +: 8];
    push_job_o.last = last_byte;
    if (in_item_i.mode == ModeStart) begin
      push_job_o.is_hdr = 1'b1;
      push_valid_o      = in_valid_i;
    end else begin
      push_job_o.is_hdr = 1'b0;
      // drop payload with no frame open
      push_valid_o      = in_valid_i && open_q;
    end
  end

  // Advance frame state on each accepted request
  always_comb begin
    key_d  = key_q;
    rem_d  = rem_q;
    pos_d  = pos_q;
    open_d = open_q;
    if (accept) begin
      if (in_item_i.mode == ModeStart) begin
        key_d  = in_item_i.mask_key;
        rem_d  = in_item_i.payload_length;
        pos_d  = 2'd0;
        open_d = (in_item_i.payload_length != '0);
      end else if (open_q) begin
        rem_d = rem_q - 63'd1;
        pos_d = pos_q + 2'd1;
        if (last_byte) begin
          open_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q  <= '0;
      rem_q  <= '0;
      pos_q  <= '0;
      open_q <= 1'b0;
    end else begin
      key_q  <= key_d;
      rem_q  <= rem_d;
      pos_q  <= pos_d;
      open_q <= open_d;
    end
  end

endmodule

[rtl/wscfm_queue.sv]
// Short request queue between the front and back ends.
// Depends on wscfm_pkg for the request type.
module wscfm_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  wscfm_pkg::job_t  push_job_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output wscfm_pkg::job_t  pop_job_o
);
  import wscfm_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign push_ready_o = (cnt_q != CntFull);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_job_o    = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store requests
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

[rtl/wscfm_back.sv]
// Back end: walks each request byte by byte into the output register.
// Depends on wscfm_pkg.
module wscfm_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  pop_valid_i,
  output logic                  pop_ready_o,
  input  wscfm_pkg::job_t       pop_job_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output wscfm_pkg::out_item_t  out_item_o
);
  import wscfm_pkg::*;

  logic [HdrIdxW-1:0] idx_q, idx_d;
  logic [HdrIdxW-1:0] len_bytes;
  logic [HdrIdxW-1:0] hdr_total;
  logic [HdrIdxW-1:0] len_pos;
  logic [HdrIdxW-1:0] key_pos;
  logic [63:0]        len64;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;
  logic               can_load;
  logic               load;
  logic               job_done;
  logic [7:0]         cur_byte;
  logic               cur_last;

  assign can_load = !out_valid_q || out_ready_i;
  assign load     = pop_valid_i && can_load;
  assign len64    = {1'b0, pop_job_i.len};

  // Pick the byte for the current step of the request
  always_comb begin
    unique case (pop_job_i.kind)
      LenDirect: len_bytes = HdrIdxW'(0);
      Len16:     len_bytes = HdrIdxW'(2);
      default:   len_bytes = HdrIdxW'(8);
    endcase
    hdr_total = HdrIdxW'(2 + MaskBytes) + len_bytes;
    len_pos   = len_bytes + HdrIdxW'(1) - idx_q;
    key_pos   = idx_q - HdrIdxW'(2) - len_bytes;
    cur_byte  = pop_job_i.data;
    cur_last  = pop_job_i.last;
    job_done  = 1'b1;
    if (pop_job_i.is_hdr) begin
      job_done = (idx_q == hdr_total - HdrIdxW'(1));
      cur_last = job_done && pop_job_i.len_zero;
      if (idx_q == HdrIdxW'(0)) begin
        cur_byte = HdrFinText;
      end else if (idx_q == HdrIdxW'(1)) begin
        unique case (pop_job_i.kind)
          LenDirect: cur_byte = HdrMaskBit | {1'b0, pop_job_i.len[6:0]};
          Len16:     cur_byte = HdrMaskBit | {1'b0, LenCode16};
          default:   cur_byte = HdrMaskBit | {1'b0, LenCode64};
        endcase
      end else if (idx_q < HdrIdxW'(2) + len_bytes) begin
        cur_byte = len64[8*len_pos[2:0] +: 8];
      end else begin
        cur_byte = pop_job_i.key[8*key_pos[1:0] +: 8];
      end
    end
  end

  assign pop_ready_o = can_load && job_done;

  // Load the output register and step through the request
  always_comb begin
    idx_d       = idx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_d.frame_byte = cur_byte;
      out_d.frame_last = cur_last;
      out_valid_d      = 1'b1;
      idx_d            = job_done ? '0 : idx_q + HdrIdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

[rtl/websocket_client_frame_masker.sv]
// Top level of the WebSocket client frame masker: front, request queue, back.
// Depends on wscfm_pkg, wscfm_front, wscfm_queue and wscfm_back.
//
// Builds masked client-to-server text frames. A start item (mode 0) produces
// the header: 0x81, the length byte with the mask bit, an optional 16-bit or
// 64-bit big-endian length, and the four mask key bytes, low byte first, for
// 6, 8 or 14 output bytes. Each payload item (mode 1) produces one masked byte;
// payload with no frame open is dropped. The output stream runs at one byte per
// cycle through a single output register while the receiver does not stall it,
// so a start item holds the output lane for all of its header bytes. The front
// end keeps taking items at one per cycle while the queue has room for them, and
// up to QueueDepth requests wait for that lane; an accepted item's request is
// written into the queue and then loaded into the output register.
module websocket_client_frame_masker #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  wscfm_pkg::in_item_t   in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output wscfm_pkg::out_item_t  out_item_o
);
  import wscfm_pkg::*;

  logic push_valid, push_ready;
  logic pop_valid, pop_ready;
  job_t push_job, pop_job;

  // Accept and classify items
  wscfm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_job_o   (push_job)
  );

  // Buffer requests between the two ends
  wscfm_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job)
  );

  // Emit bytes
  wscfm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_job_i   (pop_job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

`ifndef SYNTHESIS
  // Hold the output byte while the receiver stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("output byte changed while stalled");

  // Every accepted start item produces a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (in_item_i.mode == ModeStart)) |-> push_valid)
    else $error("start item produced no request");

  // Output becomes valid only from a queued request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(pop_valid))
    else $error("output loaded with no request pending");
`endif

endmodule
